/* rtl/saqs_pkg.sv */
// shared constants, codes and control types for the shifting array queue
`default_nettype none
package saqs_pkg;

   // queue geometry and field widths
   localparam int DEPTH  = 16;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = 5;
   localparam int POS_W  = 4;
   localparam int DATA_W = 32;
   localparam int FUNC_W = 3;

   localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_ENQ    = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_DEQ    = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_PEEK   = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_SEARCH = 3'd4;

   // controller to datapath
   typedef struct packed {
      logic op_go;      // carry out the accepted operation and load the result
      logic scan_load;  // capture the search word and restart the scan pointer
      logic scan_step;  // advance the scan pointer
      logic scan_end;   // load the search result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic start_scan; // accepted item is a search over a non-empty queue
      logic hit;        // entry under the scan pointer matches
      logic last;       // scan pointer is on the newest entry
   } sts_type;

endpackage
`default_nettype wire

/* rtl/saqs_ctrl.sv */
// controller: handshakes, scan sequencing and result valid
`default_nettype none
module saqs_ctrl (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  wire                rsp_tready,
   input  saqs_pkg::sts_type  sts,
   output saqs_pkg::cmd_type  cmd
);
   import saqs_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_xfer;

   // take a new item only once the result slot is free or emptying
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (sts.start_scan) begin
                  cmd.scan_load = 1'b1;
                  state_in      = ST_SCAN;
               end else begin
                  cmd.op_go    = 1'b1;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (sts.hit || sts.last) begin
               cmd.scan_end = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/saqs_dp.sv */
// datapath: entry shift line, fill count, capacity, scan pointer, result register
`default_nettype none
module saqs_dp (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                csr_we,
   input  wire         [saqs_pkg::CNT_W-1:0]  csr_wdata,
   input  wire         [saqs_pkg::FUNC_W-1:0] req_func,
   input  wire  signed [saqs_pkg::DATA_W-1:0] req_value,
   input  saqs_pkg::cmd_type                  cmd,
   output saqs_pkg::sts_type                  sts,
   output logic                               res_status,
   output logic signed [saqs_pkg::DATA_W-1:0] res_data,
   output logic                               res_found,
   output logic        [saqs_pkg::POS_W-1:0]  res_position,
   output logic        [saqs_pkg::CNT_W-1:0]  res_count,
   output logic                               res_empty,
   output logic                               res_full
);
   import saqs_pkg::*;

   logic signed [DATA_W-1:0] entries_ff [DEPTH];
   logic signed [DATA_W-1:0] entries_in [DEPTH];
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         cap_ff, cap_in;
   logic [CNT_W-1:0]         cap_eff;
   logic signed [DATA_W-1:0] key_ff, key_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;

   logic                     status_ff, status_in;
   logic signed [DATA_W-1:0] data_ff, data_in;
   logic                     found_ff, found_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic [CNT_W-1:0]         rcount_ff, rcount_in;
   logic                     empty_ff, empty_in;
   logic                     full_ff, full_in;
   logic                     load_res;

   // capacity saturates at the queue depth
   assign cap_eff = (cap_ff > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_ff;

   // status back to the controller
   assign sts.start_scan = (req_func == FUNC_SEARCH) && (count_ff != '0);
   assign sts.hit        = (entries_ff[idx_ff] == key_ff);
   assign sts.last       = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);

   // capacity register
   assign cap_in = csr_we ? csr_wdata : cap_ff;

   // operation, scan and result next values
   always_comb begin
      entries_in = entries_ff;
      count_in   = count_ff;
      key_in     = key_ff;
      idx_in     = idx_ff;
      status_in  = 1'b0;
      data_in    = '0;
      found_in   = 1'b0;
      pos_in     = '0;
      load_res   = 1'b0;

      if (cmd.op_go) begin
         load_res = 1'b1;
         unique case (req_func)
            FUNC_ENQ: begin
               if (count_ff >= cap_eff) begin
                  status_in = 1'b1;
               end else begin
                  entries_in[count_ff[IDX_W-1:0]] = req_value;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            FUNC_DEQ: begin
               if (count_ff == '0) begin
                  status_in = 1'b1;
               end else begin
                  data_in = entries_ff[0];
                  for (int i = 0; i < DEPTH - 1; i++) begin
                     entries_in[i] = entries_ff[i+1];
                  end
                  count_in = count_ff - CNT_W'(1);
               end
            end
            FUNC_PEEK: begin
               if (count_ff == '0) begin
                  status_in = 1'b1;
               end else begin
                  data_in = entries_ff[0];
               end
            end
            FUNC_CLEAR: begin
               count_in = '0;
            end
            default: begin
               // search over an empty queue and unused codes change nothing
            end
         endcase
      end

      if (cmd.scan_load) begin
         key_in = req_value;
         idx_in = '0;
      end

      if (cmd.scan_step) begin
         idx_in = idx_ff + IDX_W'(1);
      end

      if (cmd.scan_end) begin
         load_res = 1'b1;
         found_in = sts.hit;
         pos_in   = sts.hit ? POS_W'(idx_ff) : '0;
      end

      rcount_in = count_in;
      empty_in  = (count_in == '0);
      full_in   = (count_in >= cap_eff);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         cap_ff   <= CAP_RESET;
      end else begin
         count_ff <= count_in;
         cap_ff   <= cap_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
      key_ff     <= key_in;
      idx_ff     <= idx_in;
      if (load_res) begin
         status_ff <= status_in;
         data_ff   <= data_in;
         found_ff  <= found_in;
         pos_ff    <= pos_in;
         rcount_ff <= rcount_in;
         empty_ff  <= empty_in;
         full_ff   <= full_in;
      end
   end

   assign res_status   = status_ff;
   assign res_data     = data_ff;
   assign res_found    = found_ff;
   assign res_position = pos_ff;
   assign res_count    = rcount_ff;
   assign res_empty    = empty_ff;
   assign res_full     = full_ff;

endmodule
`default_nettype wire

/* rtl/shifting_array_queue_with_search_top.sv */
// top level of the front-aligned queue with linear search
//
//   channel  direction  fields (low bit up)
//   req      in         tuser: func[2:0]; tdata: value[31:0]
//   rsp      out        tdata: status, data[31:0], found, position[3:0],
//                              count[4:0], empty_res, full_res, zero pad
//   csr      in         capacity[4:0], written when csr_we is high
//
// enqueue, dequeue, peek, clear, unused codes and search on an empty queue load
// the result register in the cycle after the transfer. a search first loads the key,
// then steps the scan pointer over one entry per cycle until it hits a match or the
// newest entry. a new request is taken once no scan is running and the result
// register is free or being read.
// synchronous reset empties the queue and sets capacity to 16.
`default_nettype none
module shifting_array_queue_with_search_top (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,  // value[31:0]
   input  wire  [7:0]  req_tuser,  // func[2:0], zero pad
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [47:0] rsp_tdata,  // status, data, found, position, count, empty_res, full_res
   input  wire         csr_we,
   input  wire  [4:0]  csr_wdata
);
   import saqs_pkg::*;

   cmd_type                  cmd;
   sts_type                  sts;
   logic                     res_status;
   logic signed [DATA_W-1:0] res_data;
   logic                     res_found;
   logic [POS_W-1:0]         res_position;
   logic [CNT_W-1:0]         res_count;
   logic                     res_empty;
   logic                     res_full;

   // sequencing
   saqs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // storage and result
   saqs_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .req_func     (req_tuser[FUNC_W-1:0]),
      .req_value    (signed'(req_tdata)),
      .cmd          (cmd),
      .sts          (sts),
      .res_status   (res_status),
      .res_data     (res_data),
      .res_found    (res_found),
      .res_position (res_position),
      .res_count    (res_count),
      .res_empty    (res_empty),
      .res_full     (res_full)
   );

   // pack the result transfer
   assign rsp_tdata = {3'b000, res_full, res_empty, res_count, res_position,
                       res_found, res_data, res_status};

endmodule
`default_nettype wire

/* verif/shifting_array_queue_with_search_top_test.sv */
// self-checking testbench for the front-aligned queue with linear search
`timescale 1ns / 1ps
`default_nettype none
module shifting_array_queue_with_search_top_test;
   import saqs_pkg::*;

   // result word, last field in the lowest bits as on rsp_tdata
   typedef struct packed {
      logic [2:0]        pad;
      logic              full_res;
      logic              empty_res;
      logic [CNT_W-1:0]  count;
      logic [POS_W-1:0]  position;
      logic              found;
      logic [DATA_W-1:0] data;
      logic              status;
   } queue_result_type;

   typedef struct packed {
      logic              typed;
      logic [FUNC_W-1:0] func;
      logic [DATA_W-1:0] value;
      queue_result_type  want;
   } directed_row_type;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   // codes with no operation behind them
   localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO  = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED_MID = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI  = 3'd7;

   localparam logic [DATA_W-1:0] WORD_MAX  = 32'h7fff_ffff;
   localparam logic [DATA_W-1:0] WORD_MIN  = 32'h8000_0000;
   localparam logic [DATA_W-1:0] WORD_ONES = 32'hffff_ffff;

   localparam int SETTLE_CYCLES = 24;
   localparam int RETARGET_EVERY = 40;

   function automatic queue_result_type outcome(int st, logic [DATA_W-1:0] dat, int fnd,
                                                int pos, int cnt, int emp, int ful);
      queue_result_type r;
      r = '0;
      r.status = 1'(st);
      r.data = dat;
      r.found = 1'(fnd);
      r.position = POS_W'(pos);
      r.count = CNT_W'(cnt);
      r.empty_res = 1'(emp);
      r.full_res = 1'(ful);
      return r;
   endfunction

   localparam queue_result_type NO_WANT = '0;

   // directed rows, run at the reset capacity of 16
   localparam int N_DIRECTED = 24;
   localparam directed_row_type DIRECTED_ROWS [N_DIRECTED] = '{
      '{1'b1, FUNC_DEQ,        32'h0,        outcome(1, 0, 0, 0, 0, 1, 0)},
      '{1'b1, FUNC_PEEK,       32'h0,        outcome(1, 0, 0, 0, 0, 1, 0)},
      '{1'b1, FUNC_SEARCH,     32'h0,        outcome(0, 0, 0, 0, 0, 1, 0)},
      '{1'b1, FUNC_ENQ,        WORD_MAX,     outcome(0, 0, 0, 0, 1, 0, 0)},
      '{1'b1, FUNC_ENQ,        WORD_MIN,     outcome(0, 0, 0, 0, 2, 0, 0)},
      '{1'b1, FUNC_ENQ,        32'h0,        outcome(0, 0, 0, 0, 3, 0, 0)},
      '{1'b1, FUNC_ENQ,        WORD_ONES,    outcome(0, 0, 0, 0, 4, 0, 0)},
      '{1'b1, FUNC_PEEK,       32'h0,        outcome(0, WORD_MAX, 0, 0, 4, 0, 0)},
      '{1'b1, FUNC_SEARCH,     WORD_MIN,     outcome(0, 0, 1, 1, 4, 0, 0)},
      '{1'b1, FUNC_SEARCH,     WORD_ONES,    outcome(0, 0, 1, 3, 4, 0, 0)},
      '{1'b1, FUNC_SEARCH,     WORD_MAX,     outcome(0, 0, 1, 0, 4, 0, 0)},
      '{1'b1, FUNC_SEARCH,     32'h1234_5678, outcome(0, 0, 0, 0, 4, 0, 0)},
      '{1'b1, FUNC_ENQ,        32'h0,        outcome(0, 0, 0, 0, 5, 0, 0)},
      '{1'b1, FUNC_SEARCH,     32'h0,        outcome(0, 0, 1, 2, 5, 0, 0)},
      '{1'b1, FUNC_UNUSED_LO,  WORD_ONES,    outcome(0, 0, 0, 0, 5, 0, 0)},
      '{1'b0, FUNC_UNUSED_MID, 32'h0,        NO_WANT},
      '{1'b0, FUNC_UNUSED_HI,  WORD_MIN,     NO_WANT},
      '{1'b1, FUNC_DEQ,        32'h0,        outcome(0, WORD_MAX, 0, 0, 4, 0, 0)},
      '{1'b1, FUNC_DEQ,        32'h0,        outcome(0, WORD_MIN, 0, 0, 3, 0, 0)},
      '{1'b0, FUNC_SEARCH,     32'h0,        NO_WANT},
      '{1'b1, FUNC_CLEAR,      WORD_ONES,    outcome(0, 0, 0, 0, 0, 1, 0)},
      '{1'b0, FUNC_ENQ,        32'h5a5a_a5a5, NO_WANT},
      '{1'b0, FUNC_DEQ,        32'h0,        NO_WANT},
      '{1'b1, FUNC_DEQ,        32'h0,        outcome(1, 0, 0, 0, 0, 1, 0)}
   };

   // random phases: capacity written before each, idling pattern, item count
   localparam int N_PHASES = 7;
   localparam int PHASE_CAP   [N_PHASES] = '{31, 4, 0, 16, 1, 9, 20};
   localparam int PHASE_ITEMS [N_PHASES] = '{150, 120, 80, 150, 100, 150, 150};
   localparam idle_mode_type PHASE_IDLE [N_PHASES] = '{IDLE_NONE, IDLE_SENDER,
                                                       IDLE_RECEIVER, IDLE_BOTH,
                                                       IDLE_NONE, IDLE_SENDER,
                                                       IDLE_BOTH};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // value[31:0]
   logic [7:0]  req_tuser = '0;   // func[2:0], zero pad
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // status, data, found, position, count, empty_res,
                                  // full_res, zero pad
   logic        csr_we = 1'b0;
   logic [4:0]  csr_wdata = '0;   // capacity[4:0]

   // shadow queue and capacity register
   logic [DATA_W-1:0] queue_words [DEPTH];
   int                queue_fill = 0;
   int                capacity_reg = int'(CAP_RESET);
   int                fill_target = DEPTH;

   queue_result_type expected_results [$];
   int               fail_count = 0;
   idle_mode_type    idle_mode = IDLE_NONE;

   shifting_array_queue_with_search_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // carry out one operation on the shadow queue and give its result
   function automatic queue_result_type apply_request(logic [FUNC_W-1:0] func,
                                                      logic [DATA_W-1:0] value);
      queue_result_type r;
      int               limit;
      r = '0;
      limit = (capacity_reg > DEPTH) ? DEPTH : capacity_reg;
      case (func)
         FUNC_ENQ: begin
            if (queue_fill >= limit) begin
               r.status = 1'b1;
            end else begin
               queue_words[queue_fill] = value;
               queue_fill++;
            end
         end
         FUNC_DEQ: begin
            if (queue_fill == 0) begin
               r.status = 1'b1;
            end else begin
               r.data = queue_words[0];
               for (int i = 0; i + 1 < queue_fill; i++) queue_words[i] = queue_words[i + 1];
               queue_fill--;
            end
         end
         FUNC_PEEK: begin
            if (queue_fill == 0) r.status = 1'b1;
            else r.data = queue_words[0];
         end
         FUNC_CLEAR: begin
            queue_fill = 0;
         end
         FUNC_SEARCH: begin
            // first match wins
            for (int i = queue_fill - 1; i >= 0; i--) begin
               if (queue_words[i] == value) begin
                  r.found = 1'b1;
                  r.position = POS_W'(i);
               end
            end
         end
         default: ;
      endcase
      r.count = CNT_W'(queue_fill);
      r.empty_res = (queue_fill == 0);
      r.full_res = (queue_fill >= limit);
      return r;
   endfunction

   function automatic int sender_idle_pct();
      return (idle_mode == IDLE_SENDER) ? 76 : (idle_mode == IDLE_BOTH) ? 24 : 0;
   endfunction

   function automatic int receiver_stall_pct();
      return (idle_mode == IDLE_RECEIVER) ? 76 : (idle_mode == IDLE_BOTH) ? 24 : 0;
   endfunction

   // many small values so that duplicates and first-match cases are common
   function automatic logic [DATA_W-1:0] pick_word();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 4) return DATA_W'($urandom_range(0, 7)) - 32'd4;
      if (sel < 6) begin
         case ($urandom_range(0, 3))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return 32'h0;
            default: return WORD_ONES;
         endcase
      end
      return $urandom;
   endfunction

   // steer the fill level towards a moving target so that full and empty both occur
   function automatic logic [FUNC_W-1:0] pick_func();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) return FUNC_W'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
      if (r < 4) return FUNC_CLEAR;
      if (r < 24) return FUNC_SEARCH;
      if (r < 32) return FUNC_PEEK;
      if (queue_fill < fill_target) return (r < 86) ? FUNC_ENQ : FUNC_DEQ;
      return (r < 50) ? FUNC_ENQ : FUNC_DEQ;
   endfunction

   // present one request, wait for its transfer and queue its expected result
   task automatic send_request(logic [FUNC_W-1:0] func, logic [DATA_W-1:0] value,
                               logic typed, queue_result_type want);
      queue_result_type predicted;
      while ($urandom_range(0, 99) < sender_idle_pct()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      req_tuser <= {5'b0, func};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = apply_request(func, value);
      expected_results.push_back(typed ? want : predicted);
   endtask

   // let every outstanding result arrive, then give a search time to finish
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(int cap);
      csr_we <= 1'b1;
      csr_wdata <= 5'(cap);
      @(posedge clock);
      csr_we <= 1'b0;
      capacity_reg = cap;
   endtask

   task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         fail_count++;
      end
   endtask

   // receiver back-pressure and result checking
   always @(posedge clock) begin : rsp_check
      queue_result_type got;
      queue_result_type want;
      rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct());
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = queue_result_type'(rsp_tdata);
         if (expected_results.size() == 0) begin
            $error("result transfer with nothing expected: %h", rsp_tdata);
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("status",    DATA_W'(want.status),    DATA_W'(got.status));
            check_field("data",      want.data,               got.data);
            check_field("found",     DATA_W'(want.found),     DATA_W'(got.found));
            check_field("position",  DATA_W'(want.position),  DATA_W'(got.position));
            check_field("count",     DATA_W'(want.count),     DATA_W'(got.count));
            check_field("empty_res", DATA_W'(want.empty_res), DATA_W'(got.empty_res));
            check_field("full_res",  DATA_W'(want.full_res),  DATA_W'(got.full_res));
         end
      end
   end

   // stimulus
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows at the reset capacity
      idle_mode = IDLE_NONE;
      for (int i = 0; i < N_DIRECTED; i++) begin
         send_request(DIRECTED_ROWS[i].func, DIRECTED_ROWS[i].value,
                      DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
      end
      wait_idle();

      // random phases, contents carried over so capacity can drop below count
      for (int p = 0; p < N_PHASES; p++) begin
         write_capacity(PHASE_CAP[p]);
         idle_mode = PHASE_IDLE[p];
         for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
            logic [FUNC_W-1:0] func;
            logic [DATA_W-1:0] value;
            if (n % RETARGET_EVERY == 0) fill_target = $urandom_range(0, DEPTH);
            func = pick_func();
            if (func == FUNC_SEARCH && queue_fill > 0 && $urandom_range(0, 9) < 6)
               value = queue_words[$urandom_range(0, queue_fill - 1)];
            else
               value = pick_word();
            send_request(func, value, 1'b0, NO_WANT);
         end
         wait_idle();
      end

      if (fail_count == 0) begin
         $display("shifting_array_queue_with_search_top_test passed");
      end else begin
         $display("shifting_array_queue_with_search_top_test failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("shifting_array_queue_with_search_top_test failed");
      $finish;
   end

endmodule
`default_nettype wire
